FILE: hw/rtl/swqt_pkg.sv
// Shared types and register codes for the sliding window quality trimmer.
package swqt_pkg;

	// Per-base score: raw character minus ascii_base, range -255..255
	localparam int SCORE_W = 9;
	typedef logic signed [SCORE_W-1:0] score_t;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ASCII_BASE = 2'd0,
		REG_MIN_SCORE  = 2'd1,
		REG_MIN_LENGTH = 2'd2
	} cfg_reg_t;

	localparam logic [7:0]  ASCII_BASE_RST = 8'd64;
	localparam logic [7:0]  MIN_SCORE_RST  = 8'd20;
	localparam logic [10:0] MIN_LENGTH_RST = 11'd30;

	// Result fields
	localparam int START_W = 10;
	localparam int LEN_W   = 11;

	// Status handed from the end of the cell chain to the tracker
	typedef struct packed {
		logic   old_valid;  // oldest cell holds a score that drops out
		score_t old_score;
		logic   full;       // window complete after this shift
	} win_tap_t;

	// Control handed from the tracker to every cell
	typedef struct packed {
		logic   shift;
		logic   clear;
		score_t score;
	} win_step_t;

	// One trim result
	typedef struct packed {
		logic [START_W-1:0] trim_start;
		logic [LEN_W-1:0]   kept_length;
		logic               keep_read;
		logic               too_long;
	} trim_res_t;

endpackage

FILE: hw/rtl/swqt_cell.sv
// One cell of the score shift line: holds a score and its valid mark.
module swqt_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              shift,
	input  logic              clear,
	input  logic              prev_valid,
	input  swqt_pkg::score_t  prev_score,
	output logic              valid_q,
	output swqt_pkg::score_t  score_q
);
	import swqt_pkg::*;

	// valid mark: cleared at end of read, else taken from the neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clear) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= prev_valid;
		end
	end

	// score payload, read only behind valid_q
	always_ff @(posedge clk) begin
		if (shift) begin
			score_q <= prev_score;
		end
	end

endmodule

FILE: hw/rtl/swqt_track.sv
// Running window sum, qualifying-window tracking and result forming.
module swqt_track #(
	parameter int WINDOW  = 5,
	parameter int MAX_LEN = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          ascii_base,
	input  logic [7:0]          min_score,
	input  logic [10:0]         min_length,
	input  logic                acc,
	input  logic [7:0]          qual_char,
	input  logic                last_char,
	input  swqt_pkg::win_tap_t  tap,
	output swqt_pkg::win_step_t step,
	output swqt_pkg::trim_res_t res
);
	import swqt_pkg::*;

	localparam int TOT_W = $clog2(WINDOW * 255 + 1) + 1;
	localparam int POS_W = $clog2(MAX_LEN + 1);

	logic signed [TOT_W-1:0] total_q, total_nxt;
	logic [TOT_W-1:0]        thr;
	logic [POS_W-1:0]        pos_q, pos_nxt, pos_p1;
	logic [POS_W-1:0]        first_q, first_nxt;
	logic [POS_W-1:0]        end_q, end_nxt;
	logic                    found_q, found_nxt;
	logic                    ovf_q, ovf_nxt;
	logic                    sat, qual;
	score_t                  score;
	logic [POS_W-1:0]        len;
	logic [31:0]             start_w, len_w;

	// score and window sum after this character
	always_comb begin
		sat       = (pos_q == POS_W'(MAX_LEN));
		score     = score_t'(SCORE_W'(qual_char) - SCORE_W'(ascii_base));
		total_nxt = total_q + TOT_W'(score)
		            - (tap.old_valid ? TOT_W'(tap.old_score) : TOT_W'(0));
		thr       = TOT_W'(32'(min_score) * 32'(WINDOW));
		qual      = tap.full && (total_nxt > $signed(thr));
		pos_p1    = pos_q + POS_W'(1);
	end

	// per-read state after this character
	always_comb begin
		pos_nxt   = pos_q;
		found_nxt = found_q;
		first_nxt = first_q;
		end_nxt   = end_q;
		ovf_nxt   = ovf_q;
		if (acc) begin
			if (sat) begin
				ovf_nxt = 1'b1;
			end else begin
				pos_nxt = pos_p1;
				if (qual) begin
					if (!found_q) begin
						first_nxt = pos_p1 - POS_W'(WINDOW);
						found_nxt = 1'b1;
					end
					end_nxt = pos_p1;
				end
			end
		end
	end

	// result on the final character
	always_comb begin
		len     = found_nxt ? (end_nxt - first_nxt) : pos_nxt;
		start_w = found_nxt ? 32'(first_nxt) : 32'd0;
		len_w   = 32'(len);
		res.trim_start  = start_w[START_W-1:0];
		res.kept_length = len_w[LEN_W-1:0];
		res.keep_read   = (len_w > 32'(min_length));
		res.too_long    = ovf_nxt;
	end

	// control for the cell chain
	always_comb begin
		step.shift = acc && !sat;
		step.clear = acc && last_char;
		step.score = score;
	end

	// state registers, back to zero after each read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			pos_q   <= '0;
			found_q <= 1'b0;
			first_q <= '0;
			end_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (acc) begin
			if (last_char) begin
				total_q <= '0;
				pos_q   <= '0;
				found_q <= 1'b0;
				first_q <= '0;
				end_q   <= '0;
				ovf_q   <= 1'b0;
			end else begin
				if (!sat) begin
					total_q <= total_nxt;
				end
				pos_q   <= pos_nxt;
				found_q <= found_nxt;
				first_q <= first_nxt;
				end_q   <= end_nxt;
				ovf_q   <= ovf_nxt;
			end
		end
	end

endmodule

FILE: hw/rtl/sliding_window_quality_trim_core.sv
// Sliding window quality trimmer: one quality character per request in, one trim result per read.
//
// Each accepted character's score enters a shift line of WINDOW cells while a single adder
// updates the running window sum, so characters stream back to back at one per clock unless stalled.
// On the character marked last_char the trim result (start, kept length, keep and too-long flags)
// lands in the output register on the next edge; the input keeps accepting while that register is
// free or being drained. Characters beyond MAX_LEN are not scored and only set too_long. The three
// configuration registers (ascii_base, min_score, min_length) are written through the cfg port,
// which is always ready, and should be changed only between reads.
module sliding_window_quality_trim_core #(
	parameter int WINDOW  = 5,
	parameter int MAX_LEN = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// character stream
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      qual_char,
	input  logic                            last_char,
	// result stream
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [swqt_pkg::START_W-1:0]    trim_start,
	output logic [swqt_pkg::LEN_W-1:0]      kept_length,
	output logic                            keep_read,
	output logic                            too_long,
	// configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [swqt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [swqt_pkg::CFG_DATA_W-1:0] cfg_data
);
	import swqt_pkg::*;

	logic [7:0]  ascii_base_q;
	logic [7:0]  min_score_q;
	logic [10:0] min_length_q;

	logic        acc;
	win_tap_t    tap;
	win_step_t   step;
	trim_res_t   res;
	trim_res_t   res_q;
	logic        out_valid_q;

	logic   chain_in_valid [WINDOW];
	score_t chain_in_score [WINDOW];
	logic   cell_valid     [WINDOW];
	score_t cell_score     [WINDOW];

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ascii_base_q <= ASCII_BASE_RST;
			min_score_q  <= MIN_SCORE_RST;
			min_length_q <= MIN_LENGTH_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ASCII_BASE: ascii_base_q <= cfg_data[7:0];
				REG_MIN_SCORE:  min_score_q  <= cfg_data[7:0];
				REG_MIN_LENGTH: min_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input handshake: blocked only while a result is stuck in the output register
	assign in_ready = !out_valid_q || out_ready;
	assign acc      = in_valid && in_ready;

	// score shift line, new score enters cell 0
	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign chain_in_valid[i] = 1'b1;
			assign chain_in_score[i] = step.score;
		end else begin : g_body
			assign chain_in_valid[i] = cell_valid[i-1];
			assign chain_in_score[i] = cell_score[i-1];
		end

		swqt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift      (step.shift),
			.clear      (step.clear),
			.prev_valid (chain_in_valid[i]),
			.prev_score (chain_in_score[i]),
			.valid_q    (cell_valid[i]),
			.score_q    (cell_score[i])
		);
	end

	// tap at the end of the line: score leaving, and whether the window fills
	always_comb begin
		tap.old_valid = cell_valid[WINDOW-1];
		tap.old_score = cell_score[WINDOW-1];
		tap.full      = chain_in_valid[WINDOW-1];
	end

	swqt_track #(
		.WINDOW  (WINDOW),
		.MAX_LEN (MAX_LEN)
	) u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.ascii_base (ascii_base_q),
		.min_score  (min_score_q),
		.min_length (min_length_q),
		.acc        (acc),
		.qual_char  (qual_char),
		.last_char  (last_char),
		.tap        (tap),
		.step       (step),
		.res        (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc && last_char) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && last_char) begin
			res_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign trim_start  = res_q.trim_start;
	assign kept_length = res_q.kept_length;
	assign keep_read   = res_q.keep_read;
	assign too_long    = res_q.too_long;

endmodule

FILE: tb/sv/sliding_window_quality_trim_core_checker.sv
// Checker for the quality trimmer: mirrors register writes, predicts each read's trim, compares results.
`timescale 1ns / 1ps
module sliding_window_quality_trim_core_checker #(
	parameter int WINDOW  = 5,
	parameter int MAX_LEN = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic [7:0]                      qual_char,
	input  logic                            last_char,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic [swqt_pkg::START_W-1:0]    trim_start,
	input  logic [swqt_pkg::LEN_W-1:0]      kept_length,
	input  logic                            keep_read,
	input  logic                            too_long,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [swqt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [swqt_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              mismatches,
	output int                              outstanding,
	output int                              trims_checked
);
	import swqt_pkg::*;

	// register mirror
	logic [7:0]       ascii_base;
	logic [7:0]       min_score;
	logic [LEN_W-1:0] min_length;

	// per-read trim state
	score_t                        ring [WINDOW];
	logic [$clog2(WINDOW+1)-1:0]   fill;
	logic [$clog2(WINDOW)-1:0]     wptr;
	logic signed [15:0]            wsum;
	logic [LEN_W-1:0]              pos;
	logic                          found;
	logic [START_W-1:0]            first_start;
	logic [LEN_W-1:0]              last_end;
	logic                          overflowed;

	// trims predicted but not yet seen on the result port
	trim_res_t expected_trims [$];

	initial begin
		mismatches    = 0;
		outstanding   = 0;
		trims_checked = 0;
	end

	task automatic clear_trim_state();
		for (int i = 0; i < WINDOW; i++)
			ring[i] = '0;
		fill        = '0;
		wptr        = '0;
		wsum        = '0;
		pos         = '0;
		found       = 1'b0;
		first_start = '0;
		last_end    = '0;
		overflowed  = 1'b0;
	endtask

	// one character of the read; on the last one, queue the trim it closes
	task automatic track_char(logic [7:0] qc, logic is_last);
		score_t             sc;
		logic signed [15:0] thr;
		trim_res_t          res;
		logic [LEN_W-1:0]   len;
		if (pos < MAX_LEN) begin
			sc = score_t'({1'b0, qc} - {1'b0, ascii_base});
			if (fill >= WINDOW)
				wsum = wsum - ring[wptr];
			else
				fill = fill + 1'b1;
			ring[wptr] = sc;
			wsum = wsum + sc;
			wptr = (wptr == WINDOW - 1) ? '0 : wptr + 1'b1;
			thr = 16'({8'b0, min_score} * WINDOW);
			if (fill >= WINDOW && wsum > thr) begin
				if (!found) begin
					first_start = START_W'(pos + 1 - WINDOW);
					found = 1'b1;
				end
				last_end = pos + 1'b1;
			end
			pos = pos + 1'b1;
		end else begin
			overflowed = 1'b1;
		end
		if (is_last) begin
			len = found ? LEN_W'(last_end - first_start) : pos;
			res.trim_start  = found ? first_start : '0;
			res.kept_length = len;
			res.keep_read   = (len > min_length);
			res.too_long    = overflowed;
			expected_trims.insert(expected_trims.size(), res);
			clear_trim_state();
		end
	endtask

	task automatic compare_field(string what, int unsigned want, int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
		end
	endtask

	// everything is sampled at the edge, before the block's registers move
	always @(posedge clk or negedge arst_n) begin
		trim_res_t want;
		if (!arst_n) begin
			ascii_base = ASCII_BASE_RST;
			min_score  = MIN_SCORE_RST;
			min_length = MIN_LENGTH_RST;
			clear_trim_state();
			expected_trims.delete();
			outstanding <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_trims.size() == 0) begin
					mismatches++;
					$display("%0t ns: result with no read pending: expected none, actual %0d/%0d/%0d/%0d",
						$time, trim_start, kept_length, keep_read, too_long);
				end else begin
					want = expected_trims[0];
					expected_trims.delete(0);
					trims_checked++;
					compare_field("trim_start", want.trim_start, trim_start);
					compare_field("kept_length", want.kept_length, kept_length);
					compare_field("keep_read", want.keep_read, keep_read);
					compare_field("too_long", want.too_long, too_long);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ASCII_BASE: ascii_base = cfg_data[7:0];
					REG_MIN_SCORE:  min_score  = cfg_data[7:0];
					REG_MIN_LENGTH: min_length = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				track_char(qual_char, last_char);
			outstanding <= expected_trims.size();
		end
	end

endmodule

FILE: tb/sv/sliding_window_quality_trim_core_tb.sv
// Testbench top for the quality trimmer: clock, reset, read stimulus, flow control and verdict.
`timescale 1ns / 1ps
module sliding_window_quality_trim_core_tb;
	import swqt_pkg::*;

	localparam int WINDOW      = 5;
	localparam int MAX_LEN     = 1024;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_CHARS = 80;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  in_valid    = 1'b0;
	logic                  in_ready;
	logic [7:0]            qual_char   = '0;
	logic                  last_char   = 1'b0;
	logic                  out_valid;
	logic                  out_ready   = 1'b0;
	logic [START_W-1:0]    trim_start;
	logic [LEN_W-1:0]      kept_length;
	logic                  keep_read;
	logic                  too_long;
	logic                  cfg_valid   = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index   = REG_ASCII_BASE;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;

	int mismatches;
	int outstanding;
	int trims_checked;

	// flow control knobs: idle and stall in percent of cycles, plus a count of hold-off requests
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_reqs      = 0;

	int chars_sent    = 0;
	int reads_sent    = 0;
	int settings_used = 0;
	int cycles        = 0;

	// current register values, used to aim read content near the threshold
	int base_now  = ASCII_BASE_RST;
	int score_now = MIN_SCORE_RST;

	sliding_window_quality_trim_core #(.WINDOW(WINDOW), .MAX_LEN(MAX_LEN)) dut (.*);

	sliding_window_quality_trim_core_checker #(.WINDOW(WINDOW), .MAX_LEN(MAX_LEN)) u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d trims still pending", cycles, outstanding);
			$display("FAIL");
			$finish;
		end
	end

	// result side: random stalls, plus a long hold-off on request
	initial begin
		int hold_seen;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_reqs != hold_seen) begin
				hold_seen = hold_reqs;
				out_ready <= 1'b0;
				for (int n = 0; n < HOLD_CYCLES; n++)
					@(posedge clk);
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	function automatic logic [7:0] clip_byte(int v);
		if (v < 0)
			return 8'd0;
		if (v > 255)
			return 8'd255;
		return v[7:0];
	endfunction

	// one character request; valid stays up until accepted
	task automatic send_char(logic [7:0] c, logic is_last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		qual_char <= c;
		last_char <= is_last;
		do
			@(posedge clk);
		while (!in_ready);
		chars_sent++;
		if (is_last)
			reads_sent++;
	endtask

	task automatic send_run(logic [7:0] c, int n, logic closes);
		for (int i = 0; i < n; i++)
			send_char(c, closes && (i == n - 1));
	endtask

	// a read with a good core and optional poor head and tail; some reads are pure noise
	task automatic send_read(int len);
		int  head;
		int  tail;
		bit  noisy;
		logic [7:0] c;
		noisy = ($urandom_range(0, 7) == 0);
		head  = ($urandom_range(0, 2) == 0) ? $urandom_range(1, (len + 1) / 2) : 0;
		tail  = ($urandom_range(0, 2) == 0) ? $urandom_range(1, (len + 1) / 2) : 0;
		for (int i = 0; i < len; i++) begin
			if (noisy)
				c = 8'($urandom_range(0, 255));
			else if (i < head || i >= len - tail)
				c = clip_byte(base_now + int'($urandom_range(0, score_now)) - 8);
			else
				c = clip_byte(base_now + score_now + int'($urandom_range(0, 24)) - 10);
			send_char(c, i == len - 1);
		end
	endtask

	// hold the character stream until every pending trim has come out
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do
			@(posedge clk);
		while (!cfg_ready);
	endtask

	task automatic set_config(int base, int score, int min_len);
		drain();
		write_reg(REG_ASCII_BASE, CFG_DATA_W'(base));
		write_reg(REG_MIN_SCORE, CFG_DATA_W'(score));
		write_reg(REG_MIN_LENGTH, CFG_DATA_W'(min_len));
		cfg_valid <= 1'b0;
		@(posedge clk);
		base_now  = base;
		score_now = score;
		settings_used++;
	endtask

	initial begin
		int phase_chars;
		int r;
		int base;
		int score;
		int min_len;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed reads at reset settings
		set_config(ASCII_BASE_RST, MIN_SCORE_RST, MIN_LENGTH_RST);
		send_run(8'd0, 1, 1'b1);       // single character, lowest byte
		send_run(8'd255, 4, 1'b1);     // shorter than a window: untrimmed
		send_run(8'd85, 5, 1'b1);      // one window just above threshold
		send_run(8'd84, 6, 1'b1);      // sum equal to threshold does not qualify
		send_run(8'd0, 4, 1'b0);       // negative scores, then a good core, then a poor tail
		send_run(8'd100, 5, 1'b0);
		send_run(8'd0, 2, 1'b1);

		// read that runs two characters past the length limit, kept at full length
		set_config(33, 0, 1023);
		send_run(8'd33, 2, 1'b0);
		send_run(8'd73, MAX_LEN, 1'b1);

		// random reads over register settings and flow-control mixes
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin base = 64;  score = 20;  min_len = 30;   end
				1: begin base = 33;  score = 0;   min_len = 0;    end
				2: begin base = 0;   score = 254; min_len = 1024; end
				3: begin base = 255; score = 255; min_len = 1;    end
				default: begin
					r = $urandom_range(0, 3);
					base    = (r == 0) ? 33 : (r == 1) ? 64 : $urandom_range(0, 255);
					score   = $urandom_range(0, 45);
					min_len = (p == 7) ? $urandom_range(0, 1024) : $urandom_range(0, 60);
				end
			endcase
			set_config(base, score, min_len);
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
				default: begin send_idle_pct = 38; recv_stall_pct = 38; end
			endcase
			// results back up behind a long hold while reads keep coming
			if (p == 0)
				hold_reqs++;
			phase_chars = chars_sent;
			while (chars_sent - phase_chars < PHASE_CHARS) begin
				r = $urandom_range(0, 99);
				if (r < 30)
					send_read($urandom_range(1, 4));
				else if (r < 85)
					send_read($urandom_range(5, 30));
				else
					send_read($urandom_range(31, 80));
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Checked %0d trims from %0d reads, %0d characters in all.",
			trims_checked, reads_sent, chars_sent);
		$display("Register settings: %0d, with window-less, saturated and idle/stall mixes.",
			settings_used);
		if (mismatches == 0 && outstanding == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
